[design/mcg_pkg.sv]
// shared types, constants and register codes of the metronome click generator
`timescale 1ns / 1ps
package mcg_pkg;

  localparam int CLICK_LENGTH = 1024;
  localparam int CLICK_HALF   = CLICK_LENGTH / 2;
  localparam int CL_W         = $clog2(CLICK_LENGTH + 1);

  localparam int SINE_ENTRIES = 1024;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam int SINE_HALF    = SINE_ENTRIES / 2;
  localparam int SINE_QUARTER = SINE_ENTRIES / 4;

  localparam int PHASE_W  = 24;
  localparam int SAMPLE_W = 16;
  localparam int ENV_W    = 17;
  localparam int MIX_W    = 18;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
  localparam int DATA_W   = 32;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // reciprocal of 5, exact for operands below 2^32; /10 is one more shift
  localparam logic signed [MUL_W-1:0] RECIP5 = 33'sh0CCCCCCCD;
  localparam int SH_DIV5  = 34;
  localparam int SH_DIV10 = 35;
  localparam logic signed [MUL_W-1:0] HARM_MUL = 33'sd27;

  localparam logic signed [MUL_W-1:0] W_SINE_NOISE = 33'sd39322;
  localparam logic signed [MUL_W-1:0] W_NOISE      = 33'sd26214;
  localparam logic signed [MUL_W-1:0] W_SINE_WOOD  = 33'sd45875;
  localparam logic signed [MUL_W-1:0] W_HARM       = 33'sd19661;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = 66'sd32768;

  // envelope division by the click length as a reciprocal multiply
  localparam int ENV_N  = CL_W + 16;
  localparam int K_FULL = ENV_N + $clog2(CLICK_LENGTH);
  localparam int K_HALF = ENV_N + $clog2(CLICK_HALF);
  localparam longint unsigned M_FULL =
    ((64'd1 << K_FULL) + 64'(CLICK_LENGTH) - 64'd1) / 64'(CLICK_LENGTH);
  localparam longint unsigned M_HALF =
    ((64'd1 << K_HALF) + 64'(CLICK_HALF) - 64'd1) / 64'(CLICK_HALF);

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_SPT         = 3'd1,
    REG_TPB         = 3'd2,
    REG_ACCENT_PER  = 3'd3,
    REG_ACCENT_STEP = 3'd4,
    REG_NORMAL_STEP = 3'd5,
    REG_VOLUME      = 3'd6,
    REG_SOUND       = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    SOUND_SINE  = 2'd0,
    SOUND_NOISE = 2'd1,
    SOUND_WOOD  = 2'd2,
    SOUND_MUTE  = 2'd3
  } sound_t;

  typedef struct packed {
    logic                enable;
    logic [19:0]         samples_per_tick;
    logic [2:0]          ticks_per_beat;
    logic [3:0]          accent_period;
    logic [PHASE_W-1:0]  accent_step;
    logic [PHASE_W-1:0]  normal_step;
    logic [15:0]         volume;
    logic [1:0]          sound;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:           1'b0,
    samples_per_tick: 20'd24000,
    ticks_per_beat:   3'd1,
    accent_period:    4'd4,
    accent_step:      24'd524288,
    normal_step:      24'd349525,
    volume:           16'd32768,
    sound:            2'd0
  };

  typedef struct packed {
    logic en;
    logic acc;
  } mul_op_t;

  typedef logic [14:0] qtab_t [0:SINE_QUARTER];

  // unsigned restoring shift-and-subtract quotient for the series terms
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          i;
    quo = '0;
    rem = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine magnitude in Q1.15 from a 9th order series on a Q30 angle
  function automatic logic [14:0] sine_mag(input int unsigned q);
    logic [63:0]        f;
    logic [63:0]        theta;
    logic [63:0]        theta2;
    logic [63:0]        term;
    logic [63:0]        div;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    int                 n;
    f      = 64'(q) << (32 - SINE_BITS);
    theta  = (f * PI_Q30) >> 31;
    theta2 = (theta * theta) >> 30;
    term   = theta;
    sum    = signed'(theta);
    for (n = 1; n <= 4; n++) begin
      div  = 64'((2 * n) * (2 * n + 1));
      term = udiv64((term * theta2) >> 30, div);
      if ((n & 1) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    int    i;
    for (i = 0; i <= SINE_QUARTER; i++) begin
      t[i] = sine_mag(i);
    end
    return t;
  endfunction

endpackage

[design/mcg_if.sv]
// sample and click channel interfaces
`timescale 1ns / 1ps
interface mcg_in_if;
  logic valid;
  logic ready;
  logic sample_strobe;

  modport source (output valid, output sample_strobe, input ready);
  modport sink (input valid, input sample_strobe, output ready);
endinterface

interface mcg_out_if import mcg_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] click_sample;
  logic                       beat_start;
  logic                       accent_now;

  modport source (output valid, output click_sample, output beat_start, output accent_now,
                  input ready);
  modport sink (input valid, input click_sample, input beat_start, input accent_now,
                output ready);
endinterface

[design/metronome_click_generator_top.sv]
// metronome click generator: sequencer, click state and output register
`timescale 1ns / 1ps
// Each transfer on sample_ch is one audio sample period; each one gives exactly
// one transfer on click_ch with click_sample, beat_start and accent_now.
// The apb port holds the eight settings; write them only while no sample is
// in flight. pready is always high, reads return the register value.
// One shared 33x33 multiply-accumulate unit does every product (step scaling,
// envelope, gain, mixing) under a small sequencer, one product per cycle, and
// a one-port sine rom is read twice per sample with a click sounding.
// A plain sample runs the envelope, gain, mix and scale steps; a beat or accent
// tick first works out the harmonic step, and a sub-tick also scales its tone
// step. Once the click has died out a sample goes to the final step, as when
// disabled or strobe is low; sample_ch is ready again once the result is loaded.
// The result sits in an output register; the next sample is accepted while it
// waits, and when click_ch stalls the sequencer holds its finished result
// until the register is free.
// Reset (synchronous, rst high) loads the register defaults, clears the
// counters and the click, and seeds the noise lfsr; nothing is pending.
module metronome_click_generator_top import mcg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mcg_in_if.sink            sample_ch,
  mcg_out_if.source         click_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_TICK    = 14'b00000000000010,
    S_SUBSTEP = 14'b00000000000100,
    S_HARM1   = 14'b00000000001000,
    S_HARM2   = 14'b00000000010000,
    S_HARM3   = 14'b00000000100000,
    S_CLICK   = 14'b00000001000000,
    S_ENV     = 14'b00000010000000,
    S_GAIN    = 14'b00000100000000,
    S_MIXA    = 14'b00001000000000,
    S_MIXB    = 14'b00010000000000,
    S_MIXC    = 14'b00100000000000,
    S_SCALE   = 14'b01000000000000,
    S_FIN     = 14'b10000000000000
  } state_t;

  localparam int Y_W = PROD_W - 16;
  localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32767);
  localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(32768);

  cfg_t   cfg;
  state_t state;

  logic [19:0]         sample_count;
  logic [1:0]          sub_index;
  logic [3:0]          beat_in_bar;
  logic [CL_W-1:0]     click_left;
  logic                sub_tick_flag;
  logic                accent_flag;
  logic [PHASE_W-1:0]  tone_phase;
  logic [PHASE_W-1:0]  tone_step;
  logic [PHASE_W-1:0]  harmonic_phase;
  logic [PHASE_W-1:0]  harmonic_step;
  logic [15:0]         noise_lfsr;
  logic                silent;
  logic                beat_flag;

  logic signed [SAMPLE_W-1:0] s_val;
  logic signed [SAMPLE_W-1:0] h_val;
  logic [ENV_W-1:0]           gain;
  logic signed [MIX_W-1:0]    mix;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_beat;
  logic                       out_accent;

  mul_op_t                   mul_op;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  rnd;
  logic [ENV_W-1:0]          env;
  logic signed [Y_W-1:0]     y_wide;
  logic signed [SAMPLE_W-1:0] y_sat;

  logic [SINE_BITS-1:0]       rom_idx;
  logic signed [SAMPLE_W-1:0] rom_q;

  logic [2:0]  tpb_eff;
  logic [1:0]  sub_eff;
  logic [3:0]  beat_eff;
  logic [2:0]  sub_inc;
  logic [4:0]  beat_inc;
  logic        tick_accent;
  logic        tick_sub;
  logic [20:0] count_inc;
  logic [15:0] lfsr_next;
  logic signed [SAMPLE_W-1:0] noise_val;
  logic [15:0] vol_eff;
  logic        accept;
  logic        out_free;

  mcg_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcg_sine_rom u_rom (
    .clk  (clk),
    .idx  (rom_idx),
    .data (rom_q)
  );

  mcg_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign sample_ch.ready    = (state == S_IDLE);
  assign accept             = sample_ch.valid && (state == S_IDLE);
  assign click_ch.valid        = out_valid;
  assign click_ch.click_sample = out_sample;
  assign click_ch.beat_start   = out_beat;
  assign click_ch.accent_now   = out_accent;
  assign out_free           = !out_valid || click_ch.ready;

  // tick bookkeeping with out-of-range counters taken as zero
  always_comb begin
    if (cfg.ticks_per_beat == 3'd0) begin
      tpb_eff = 3'd1;
    end else if (cfg.ticks_per_beat inside {[3'd5:3'd7]}) begin
      tpb_eff = 3'd4;
    end else begin
      tpb_eff = cfg.ticks_per_beat;
    end
    sub_eff     = ({1'b0, sub_index} >= tpb_eff) ? 2'd0 : sub_index;
    beat_eff    = (beat_in_bar >= cfg.accent_period) ? 4'd0 : beat_in_bar;
    tick_accent = (cfg.accent_period != 4'd0) && (sub_eff == 2'd0) && (beat_eff == 4'd0);
    tick_sub    = (sub_eff != 2'd0);
    sub_inc     = {1'b0, sub_eff} + 3'd1;
    beat_inc    = {1'b0, beat_eff} + 5'd1;
    count_inc   = {1'b0, sample_count} + 21'd1;
  end

  assign lfsr_next = noise_lfsr[0] ? ((noise_lfsr >> 1) ^ LFSR_TAPS) : (noise_lfsr >> 1);
  assign noise_val = signed'({~noise_lfsr[15], noise_lfsr[14:0]});
  assign vol_eff   = sub_tick_flag ? (cfg.volume >> 1) : cfg.volume;

  assign rnd    = prod + ROUND_BIAS;
  assign env    = sub_tick_flag ? prod[K_HALF +: ENV_W] : prod[K_FULL +: ENV_W];
  assign y_wide = rnd[PROD_W-1:16];

  always_comb begin
    if (y_wide > Y_MAX) begin
      y_sat = 16'sh7FFF;
    end else if (y_wide < Y_MIN) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_wide[SAMPLE_W-1:0];
    end
  end

  assign rom_idx = (state == S_ENV) ? harmonic_phase[PHASE_W-1 -: SINE_BITS]
                                    : tone_phase[PHASE_W-1 -: SINE_BITS];

  // operand selection for the shared multiplier
  always_comb begin
    mul_op = '0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_TICK: begin
        mul_op.en = 1'b1;
        mul_a     = signed'(MUL_W'({cfg.normal_step, 2'b00}));
        mul_b     = RECIP5;
      end
      S_HARM1: begin
        mul_op.en = 1'b1;
        mul_a     = signed'(MUL_W'(tone_step));
        mul_b     = HARM_MUL;
      end
      S_HARM2: begin
        mul_op.en = 1'b1;
        mul_a     = signed'({1'b0, prod[MUL_W-2:0]});
        mul_b     = RECIP5;
      end
      S_CLICK: begin
        mul_op.en = 1'b1;
        mul_a     = signed'(MUL_W'({click_left, 16'd0}));
        mul_b     = sub_tick_flag ? signed'(MUL_W'(M_HALF)) : signed'(MUL_W'(M_FULL));
      end
      S_ENV: begin
        mul_op.en = 1'b1;
        mul_a     = signed'(MUL_W'(env));
        mul_b     = signed'(MUL_W'(env));
      end
      S_GAIN: begin
        mul_op.en = 1'b1;
        mul_a     = signed'(MUL_W'(rnd[16 +: ENV_W]));
        mul_b     = signed'(MUL_W'(vol_eff));
      end
      S_MIXA: begin
        mul_op.en = 1'b1;
        mul_a     = MUL_W'(s_val);
        mul_b     = (cfg.sound == SOUND_WOOD) ? W_SINE_WOOD : W_SINE_NOISE;
      end
      S_MIXB: begin
        mul_op.en  = 1'b1;
        mul_op.acc = 1'b1;
        mul_a      = (cfg.sound == SOUND_WOOD) ? MUL_W'(h_val) : MUL_W'(noise_val);
        mul_b      = (cfg.sound == SOUND_WOOD) ? W_HARM : W_NOISE;
      end
      S_SCALE: begin
        mul_op.en = 1'b1;
        mul_a     = MUL_W'(mix);
        mul_b     = signed'(MUL_W'(gain));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sample_count   <= '0;
      sub_index      <= '0;
      beat_in_bar    <= '0;
      click_left     <= '0;
      sub_tick_flag  <= 1'b0;
      accent_flag    <= 1'b0;
      tone_phase     <= '0;
      tone_step      <= '0;
      harmonic_phase <= '0;
      harmonic_step  <= '0;
      noise_lfsr     <= LFSR_SEED;
      silent         <= 1'b1;
      beat_flag      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (click_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            beat_flag <= 1'b0;
            silent    <= !(sample_ch.sample_strobe && cfg.enable);
            state     <= (sample_ch.sample_strobe && cfg.enable) ? S_TICK : S_FIN;
          end
        end
        S_TICK: begin
          sample_count <= (count_inc >= {1'b0, cfg.samples_per_tick}) ? 20'd0
                                                                     : count_inc[19:0];
          if (sample_count == 20'd0) begin
            accent_flag    <= tick_accent;
            sub_tick_flag  <= tick_sub;
            click_left     <= tick_sub ? CL_W'(CLICK_HALF) : CL_W'(CLICK_LENGTH);
            tone_phase     <= '0;
            harmonic_phase <= '0;
            beat_flag      <= !tick_sub;
            if (tick_accent) begin
              tone_step <= cfg.accent_step;
            end else begin
              tone_step <= cfg.normal_step;
            end
            if (sub_inc >= tpb_eff) begin
              sub_index   <= 2'd0;
              beat_in_bar <= (beat_inc >= {1'b0, cfg.accent_period}) ? 4'd0 : beat_inc[3:0];
            end else begin
              sub_index   <= sub_inc[1:0];
              beat_in_bar <= beat_eff;
            end
            state <= (tick_sub && !tick_accent) ? S_SUBSTEP : S_HARM1;
          end else begin
            state <= S_CLICK;
          end
        end
        S_SUBSTEP: begin
          // four fifths of the normal step
          tone_step <= prod[SH_DIV5 +: PHASE_W];
          state     <= S_HARM1;
        end
        S_HARM1: state <= S_HARM2;
        S_HARM2: state <= S_HARM3;
        S_HARM3: begin
          harmonic_step <= prod[SH_DIV10 +: PHASE_W];
          state         <= S_CLICK;
        end
        S_CLICK: begin
          if (click_left == '0) begin
            silent <= 1'b1;
            state  <= S_FIN;
          end else begin
            if (cfg.sound == SOUND_NOISE) begin
              noise_lfsr <= lfsr_next;
            end
            state <= S_ENV;
          end
        end
        S_ENV: begin
          s_val <= rom_q;
          state <= S_GAIN;
        end
        S_GAIN: begin
          h_val <= rom_q;
          state <= S_MIXA;
        end
        S_MIXA: begin
          gain  <= rnd[16 +: ENV_W];
          state <= S_MIXB;
        end
        S_MIXB: state <= S_MIXC;
        S_MIXC: begin
          case (cfg.sound)
            SOUND_SINE:  mix <= MIX_W'(s_val);
            SOUND_NOISE: mix <= rnd[16 +: MIX_W];
            SOUND_WOOD:  mix <= rnd[16 +: MIX_W];
            default:     mix <= '0;
          endcase
          state <= S_SCALE;
        end
        S_SCALE: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_sample <= silent ? '0 : y_sat;
            out_beat   <= beat_flag;
            out_accent <= silent ? 1'b0 : accent_flag;
            if (!silent) begin
              tone_phase     <= tone_phase + tone_step;
              harmonic_phase <= harmonic_phase + harmonic_step;
              click_left     <= click_left - CL_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result appears only out of the final step
  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result loaded outside final step");

  // an accepted sample starts work or goes straight to a silent result
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (sample_ch.valid && sample_ch.ready) |=> (state == S_TICK || state == S_FIN))
    else $error("bad step after accepted sample");

  // a stalled result keeps its product
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && $past(state == S_FIN)) |-> $stable(prod))
    else $error("product changed while result waits");

  // sub-tick clicks never run longer than half a click
  a_sub_len: assert property (@(posedge clk) disable iff (rst)
    (sub_tick_flag && click_left != '0) |-> (click_left <= CL_W'(CLICK_HALF)))
    else $error("sub-tick click too long");

endmodule

[design/mcg_apb_regs.sv]
// apb configuration register file
`timescale 1ns / 1ps
module mcg_apb_regs import mcg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ENABLE:      cfg.enable           <= pwdata[0];
        REG_SPT:         cfg.samples_per_tick <= pwdata[19:0];
        REG_TPB:         cfg.ticks_per_beat   <= pwdata[2:0];
        REG_ACCENT_PER:  cfg.accent_period    <= pwdata[3:0];
        REG_ACCENT_STEP: cfg.accent_step      <= pwdata[PHASE_W-1:0];
        REG_NORMAL_STEP: cfg.normal_step      <= pwdata[PHASE_W-1:0];
        REG_VOLUME:      cfg.volume           <= pwdata[15:0];
        REG_SOUND:       cfg.sound            <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE:      prdata = DATA_W'(cfg.enable);
      REG_SPT:         prdata = DATA_W'(cfg.samples_per_tick);
      REG_TPB:         prdata = DATA_W'(cfg.ticks_per_beat);
      REG_ACCENT_PER:  prdata = DATA_W'(cfg.accent_period);
      REG_ACCENT_STEP: prdata = DATA_W'(cfg.accent_step);
      REG_NORMAL_STEP: prdata = DATA_W'(cfg.normal_step);
      REG_VOLUME:      prdata = DATA_W'(cfg.volume);
      REG_SOUND:       prdata = DATA_W'(cfg.sound);
      default:         prdata = '0;
    endcase
  end

endmodule

[design/mcg_sine_rom.sv]
// quarter-wave sine rom with sign fold and registered read
`timescale 1ns / 1ps
module mcg_sine_rom import mcg_pkg::*; (
  input  logic                       clk,
  input  logic [SINE_BITS-1:0]       idx,
  output logic signed [SAMPLE_W-1:0] data
);

  localparam qtab_t QTAB = build_qtab();

  logic                       neg;
  logic [SINE_BITS-2:0]       k;
  logic [SINE_BITS-1:0]       mirror;
  logic [SINE_BITS-2:0]       q;
  logic signed [SAMPLE_W-1:0] mag;

  assign neg    = idx[SINE_BITS-1];
  assign k      = idx[SINE_BITS-2:0];
  assign mirror = SINE_BITS'(SINE_HALF) - {1'b0, k};
  // second quarter reads the first one mirrored
  assign q      = (k > (SINE_BITS-1)'(SINE_QUARTER)) ? mirror[SINE_BITS-2:0] : k;
  assign mag    = signed'({1'b0, QTAB[q]});

  always_ff @(posedge clk) begin
    data <= neg ? -mag : mag;
  end

endmodule

[design/mcg_mul.sv]
// shared signed multiply-accumulate unit with registered product
`timescale 1ns / 1ps
module mcg_mul import mcg_pkg::*; (
  input  logic                     clk,
  input  mul_op_t                  op,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] product;

  assign product = a * b;

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod <= op.acc ? (prod + product) : product;
    end
  end

endmodule

[bench/tb_metronome_click_generator_top.sv]
// self-checking testbench of the metronome click generator: directed and random samples
`timescale 1ns / 1ps
module tb_metronome_click_generator_top;
  import mcg_pkg::*;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          PHASE_COUNT   = 8;
  localparam int          PHASE_ITEMS   = 225;
  localparam longint unsigned ANGLE_PI  = 64'd3373259426;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       beat;
    logic                       accent;
  } click_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mcg_in_if  sample_ch ();
  mcg_out_if click_ch ();

  metronome_click_generator_top dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .click_ch  (click_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow of the registers and the sequencer state
  cfg_t        regs_model;
  logic [19:0] samp_cnt;
  int unsigned sub_pos;
  int unsigned bar_pos;
  int unsigned click_rem;
  logic        in_sub;
  logic        in_accent;
  logic [23:0] tone_ph;
  logic [23:0] tone_inc;
  logic [23:0] harm_ph;
  logic [23:0] harm_inc;
  logic [15:0] noise;
  int          sine_lut [SINE_ENTRIES];

  click_t clicks_due [$];
  int     errors         = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     hold_tag       = 0;
  int     hold_len       = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int sine_value(input int unsigned k);
    longint unsigned f;
    longint unsigned theta;
    longint unsigned theta2;
    longint unsigned term;
    longint unsigned mag;
    longint          sum;
    logic            neg;
    f   = (64'(k) << 32) / 64'(SINE_ENTRIES);
    neg = 1'b0;
    if (f >= 64'h8000_0000) begin
      neg = 1'b1;
      f   = f - 64'h8000_0000;
    end
    if (f > 64'h4000_0000) begin
      f = 64'h8000_0000 - f;
    end
    theta  = (f * ANGLE_PI) >> 31;
    theta2 = (theta * theta) >> 30;
    term   = theta;
    sum    = longint'(theta);
    for (int n = 1; n <= 4; n++) begin
      term = ((term * theta2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return neg ? -int'(mag) : int'(mag);
  endfunction

  function automatic longint rnd16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic int sine_at(input logic [23:0] ph);
    return sine_lut[int'((64'(ph) * SINE_ENTRIES) >> 24)];
  endfunction

  // advances the shadow state by one sample period and returns the click sample
  function automatic click_t next_click(input logic strobe);
    int unsigned tpb;
    int unsigned cnt;
    int          tone;
    int          nz;
    longint      mix;
    longint      span;
    longint      env;
    longint      env2;
    longint      vol;
    longint      gain;
    longint      y;
    logic        lsb;
    click_t      r;
    r = '0;
    if (!strobe || !regs_model.enable) begin
      return r;
    end
    tpb = regs_model.ticks_per_beat;
    if (tpb < 1) begin
      tpb = 1;
    end
    if (tpb > 4) begin
      tpb = 4;
    end
    if (samp_cnt == 0) begin
      // counters left out of range by a register change restart at the tick
      if (sub_pos >= tpb) begin
        sub_pos = 0;
      end
      if (bar_pos >= regs_model.accent_period) begin
        bar_pos = 0;
      end
      in_accent = (regs_model.accent_period != 0) && sub_pos == 0 && bar_pos == 0;
      in_sub    = (sub_pos != 0);
      click_rem = in_sub ? CLICK_LENGTH / 2 : CLICK_LENGTH;
      tone_ph   = '0;
      harm_ph   = '0;
      if (in_accent) begin
        tone_inc = regs_model.accent_step;
      end else if (in_sub) begin
        tone_inc = 24'((64'(regs_model.normal_step) * 64'd4) / 64'd5);
      end else begin
        tone_inc = regs_model.normal_step;
      end
      harm_inc = 24'((64'(tone_inc) * 64'd27) / 64'd10);
      r.beat   = (sub_pos == 0);
      sub_pos++;
      if (sub_pos >= tpb) begin
        sub_pos = 0;
        bar_pos++;
        if (bar_pos >= regs_model.accent_period) begin
          bar_pos = 0;
        end
      end
    end
    if (click_rem > 0) begin
      tone     = sine_at(tone_ph);
      r.accent = in_accent;
      case (sound_t'(regs_model.sound))
        SOUND_SINE: begin
          mix = tone;
        end
        SOUND_NOISE: begin
          lsb   = noise[0];
          noise = noise >> 1;
          if (lsb) begin
            noise = noise ^ LFSR_TAPS;
          end
          nz  = int'(noise) - 32768;
          mix = rnd16(longint'(tone) * 39322 + longint'(nz) * 26214);
        end
        SOUND_WOOD: begin
          mix = rnd16(longint'(tone) * 45875 + longint'(sine_at(harm_ph)) * 19661);
        end
        default: begin
          mix = 0;
        end
      endcase
      span = in_sub ? CLICK_LENGTH / 2 : CLICK_LENGTH;
      env  = (longint'(click_rem) << 16) / span;
      env2 = (env * env + 32768) >> 16;
      vol  = in_sub ? longint'(regs_model.volume >> 1) : longint'(regs_model.volume);
      gain = (env2 * vol + 32768) >> 16;
      y    = rnd16(mix * gain);
      if (y > 32767) begin
        y = 32767;
      end
      if (y < -32768) begin
        y = -32768;
      end
      r.sample = 16'(y);
      tone_ph  = tone_ph + tone_inc;
      harm_ph  = harm_ph + harm_inc;
      click_rem--;
    end
    cnt = int'(samp_cnt) + 1;
    if (cnt >= regs_model.samples_per_tick) begin
      cnt = 0;
    end
    samp_cnt = 20'(cnt);
    return r;
  endfunction

  task automatic send_sample(input logic strobe);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.sample_strobe <= strobe;
    @(posedge clk);
    while (!sample_ch.ready) begin
      @(posedge clk);
    end
    clicks_due.push_back(next_click(strobe));
  endtask

  // sender pauses until every expected result is in, then the block runs dry
  task automatic settle_block();
    sample_ch.valid <= 1'b0;
    while (clicks_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE:      regs_model.enable           = value[0];
      REG_SPT:         regs_model.samples_per_tick = value[19:0];
      REG_TPB:         regs_model.ticks_per_beat   = value[2:0];
      REG_ACCENT_PER:  regs_model.accent_period    = value[3:0];
      REG_ACCENT_STEP: regs_model.accent_step      = value[PHASE_W-1:0];
      REG_NORMAL_STEP: regs_model.normal_step      = value[PHASE_W-1:0];
      REG_VOLUME:      regs_model.volume           = value[15:0];
      REG_SOUND:       regs_model.sound            = value[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_ENABLE, 32'(c.enable));
    write_reg(REG_SPT, 32'(c.samples_per_tick));
    write_reg(REG_TPB, 32'(c.ticks_per_beat));
    write_reg(REG_ACCENT_PER, 32'(c.accent_period));
    write_reg(REG_ACCENT_STEP, 32'(c.accent_step));
    write_reg(REG_NORMAL_STEP, 32'(c.normal_step));
    write_reg(REG_VOLUME, 32'(c.volume));
    write_reg(REG_SOUND, 32'(c.sound));
  endtask

  function automatic cfg_t random_settings();
    cfg_t c;
    int   pick;
    c.enable = 1'b1;
    pick     = $urandom_range(9);
    // mostly short tick spacing, some long enough to hear a click decay out
    if (pick < 3) begin
      c.samples_per_tick = 20'($urandom_range(6, 1));
    end else if (pick < 6) begin
      c.samples_per_tick = 20'($urandom_range(120, 7));
    end else if (pick < 8) begin
      c.samples_per_tick = 20'($urandom_range(1400, 400));
    end else if (pick == 8) begin
      c.samples_per_tick = '0;
    end else begin
      c.samples_per_tick = 20'($urandom_range(20'hFFFFF, 1401));
    end
    c.ticks_per_beat = 3'($urandom_range(7));
    c.accent_period  = 4'($urandom_range(15));
    c.accent_step    = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(1 << 20));
    c.normal_step    = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(1 << 20));
    c.volume         = 16'($urandom);
    c.sound          = 2'($urandom_range(3));
    return c;
  endfunction

  task automatic test_idle_after_reset();
    send_sample(1'b1);
    send_sample(1'b0);
    settle_block();
  endtask

  // accent, normal and sub-tick clicks with a tick on every strobed sample
  task automatic test_click_kinds();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_SPT, 32'd1);
    write_reg(REG_TPB, 32'd3);
    write_reg(REG_ACCENT_PER, 32'd2);
    write_reg(REG_ACCENT_STEP, 32'd0);
    write_reg(REG_NORMAL_STEP, 32'hFF_FFFF);
    write_reg(REG_VOLUME, 32'hFFFF);
    write_reg(REG_SOUND, 32'(SOUND_SINE));
    for (int i = 0; i < 7; i++) begin
      send_sample(i != 3);
    end
    settle_block();
  endtask

  task automatic test_timbres();
    write_reg(REG_SPT, 32'd0);
    write_reg(REG_TPB, 32'd1);
    write_reg(REG_ACCENT_PER, 32'd0);
    write_reg(REG_NORMAL_STEP, 32'h12_3456);
    write_reg(REG_SOUND, 32'(SOUND_NOISE));
    send_sample(1'b1);
    send_sample(1'b1);
    settle_block();
    write_reg(REG_SOUND, 32'(SOUND_WOOD));
    send_sample(1'b1);
    send_sample(1'b1);
    settle_block();
    write_reg(REG_VOLUME, 32'd0);
    send_sample(1'b1);
    settle_block();
    write_reg(REG_VOLUME, 32'hFFFF);
    write_reg(REG_SOUND, 32'(SOUND_MUTE));
    send_sample(1'b1);
    send_sample(1'b1);
    settle_block();
  endtask

  // out-of-range subdivision and bar counters, widest tick spacing
  task automatic test_odd_settings();
    write_reg(REG_SOUND, 32'(SOUND_SINE));
    write_reg(REG_SPT, 32'd1);
    write_reg(REG_TPB, 32'd4);
    write_reg(REG_ACCENT_PER, 32'd15);
    repeat (3) send_sample(1'b1);
    settle_block();
    write_reg(REG_TPB, 32'd2);
    write_reg(REG_ACCENT_PER, 32'd1);
    repeat (2) send_sample(1'b1);
    settle_block();
    write_reg(REG_TPB, 32'd7);
    send_sample(1'b1);
    settle_block();
    write_reg(REG_TPB, 32'd0);
    write_reg(REG_SPT, 32'hF_FFFF);
    repeat (2) send_sample(1'b1);
    settle_block();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      apply_settings(random_settings());
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 0;
        end
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct <= 70;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct <= 7;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample($urandom_range(99) >= 8);
      end
      settle_block();
    end
  endtask

  // receiver holds off long enough to back up the sample input
  task automatic test_backpressure();
    cfg_t c;
    c                  = random_settings();
    c.samples_per_tick = 20'd5;
    c.ticks_per_beat   = 3'd3;
    c.accent_period    = 4'd4;
    c.sound            = 2'(SOUND_WOOD);
    apply_settings(c);
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    hold_len       <= 400;
    hold_tag       <= hold_tag + 1;
    repeat (60) send_sample(1'b1);
    settle_block();
    repeat (40) send_sample(1'b1);
    settle_block();
  endtask

  initial begin : click_receiver
    int hold_left;
    int seen_tag;
    hold_left      = 0;
    seen_tag       = 0;
    click_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_tag != seen_tag) begin
        seen_tag  = hold_tag;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        click_ch.ready <= 1'b0;
      end else begin
        click_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : click_checker
    click_t want;
    forever begin
      @(posedge clk);
      if (!rst && click_ch.valid && click_ch.ready) begin
        if (clicks_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, click_sample %0d beat_start %0b accent_now %0b",
                   $time, click_ch.click_sample, click_ch.beat_start, click_ch.accent_now);
        end else begin
          want = clicks_due.pop_front();
          if (click_ch.click_sample !== want.sample) begin
            errors++;
            $display("%0t: click_sample expected %0d got %0d", $time,
                     $signed(want.sample), click_ch.click_sample);
          end
          if (click_ch.beat_start !== want.beat) begin
            errors++;
            $display("%0t: beat_start expected %0b got %0b", $time, want.beat,
                     click_ch.beat_start);
          end
          if (click_ch.accent_now !== want.accent) begin
            errors++;
            $display("%0t: accent_now expected %0b got %0b", $time, want.accent,
                     click_ch.accent_now);
          end
        end
      end
    end
  end

  initial begin : run_limit
    #5000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst                     <= 1'b1;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    sample_ch.valid         <= 1'b0;
    sample_ch.sample_strobe <= 1'b0;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      sine_lut[k] = sine_value(k);
    end
    regs_model = CFG_RESET;
    samp_cnt   = '0;
    sub_pos    = 0;
    bar_pos    = 0;
    click_rem  = 0;
    in_sub     = 1'b0;
    in_accent  = 1'b0;
    tone_ph    = '0;
    tone_inc   = '0;
    harm_ph    = '0;
    harm_inc   = '0;
    noise      = LFSR_SEED;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_after_reset();
    test_click_kinds();
    test_timbres();
    test_odd_settings();
    test_random_phases();
    test_backpressure();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
design/mcg_pkg.sv
design/mcg_if.sv
design/mcg_apb_regs.sv
design/mcg_sine_rom.sv
design/mcg_mul.sv
design/metronome_click_generator_top.sv
bench/tb_metronome_click_generator_top.sv
